[rtl/bpe_pkg.sv]
// Shared types and constants for the breakpoint envelope generator.
// No dependencies; imported by the top level, bpe_lerp and the bench.
`default_nettype none
package bpe_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_TIME_INC    = 1'b1;

  localparam logic [6:0]  POINT_COUNT_RESET = 7'd2;
  localparam logic [31:0] TIME_INC_RESET    = 32'd349;

  localparam logic [65:0] QUOT_LIMIT = 66'h2_0000_0000;
  localparam logic signed [35:0] VAL_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] VAL_MIN = -36'sh0_8000_0000;

  typedef struct packed {
    logic [31:0]        pos;
    logic [31:0]        left_time;
    logic signed [31:0] left_value;
    logic signed [32:0] height;
    logic [31:0]        width;
  } lerp_req_t;

endpackage
`default_nettype wire

[rtl/breakpoint_envelope_generator.sv]
// Top level of the breakpoint envelope generator: sequencer, span registers, output register.
// Depends on bpe_pkg, bpe_store and bpe_lerp.
//
// Items arrive on the in_* valid/ready channel; each gives exactly one result on the
// out_* valid/ready channel. req_type selects a load, a restart or a tick.
// Configuration writes (point count, time increment) go through cfg_we_i and are
// taken at once; the user must make them only while the block is idle, which is not enforced.
// A load goes straight to the done state. A restart reads both span ends from the single-port
// table in turn (states RDL, RDR, RDC). A tick runs a shift-add multiply and a restoring
// divide, then the advance state, and reads the next span when it moves on to it.
// A tick after the end of the stream goes straight to the done state; one on a zero-width span
// skips the arithmetic and goes to the advance state, reading the next span when it moves on.
// One item is worked on at a time; the next is taken as soon as the result has
// moved into the output register, even if the receiver has not yet taken it.
// A stalled receiver holds the result and, after that, the sequencer.
// Reset clears the span state and marks the stream ended; the breakpoint table
// is not cleared and must be loaded before a restart.
`default_nettype none
module breakpoint_envelope_generator import bpe_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [5:0]  point_index_i,
  input  wire logic [31:0] point_time_i,
  input  wire logic [31:0] point_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      sample_value_o,
  output logic             stream_ended_o,
  output logic             is_sample_o,
  output logic             load_error_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CB = $clog2(MAX_POINTS + 1);
  localparam int unsigned CW = CB > 7 ? CB : 7;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MATH = 3'd1;
  localparam logic [2:0] S_ADV  = 3'd2;
  localparam logic [2:0] S_RDL  = 3'd3;
  localparam logic [2:0] S_RDR  = 3'd4;
  localparam logic [2:0] S_RDC  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [6:0]  pcount_q;
  logic [31:0] tinc_q;
  logic [31:0] pos_q, pos_d;
  logic [CW-1:0] lidx_q, lidx_d;
  logic [31:0] ltime_q, ltime_d, rtime_q, rtime_d;
  logic signed [31:0] lval_q, lval_d, rval_q, rval_d;
  logic [31:0] width_q, width_d;
  logic signed [32:0] height_q, height_d;
  logic        more_q, more_d;
  logic [31:0] rs_val_q, rs_val_d;
  logic        rs_end_q, rs_end_d, rs_smp_q, rs_smp_d, rs_err_q, rs_err_d;
  logic        ov_q, ov_d;
  logic [31:0] o_val_q, o_val_d;
  logic        o_end_q, o_end_d, o_smp_q, o_smp_d, o_err_q, o_err_d;

  logic [CW-1:0] eff, pc_ext, max_ext, li_next;
  logic          accept, load_err, mem_we, lerp_start, lerp_done;
  logic [AW-1:0] raddr;
  logic [31:0]   rd_time, rd_value, lerp_res;
  logic [32:0]   next_pos;
  lerp_req_t     lreq;

  always_comb begin
    pc_ext = CW'(pcount_q);
    max_ext = CW'(MAX_POINTS);
    if (pc_ext < CW'(2)) eff = CW'(2);
    else if (pc_ext > max_ext) eff = max_ext;
    else eff = pc_ext;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign load_err = CW'(point_index_i) >= eff;
  assign mem_we = accept && (req_type_i == REQ_LOAD) && !load_err;
  assign li_next = lidx_q + CW'(1);
  assign next_pos = {1'b0, pos_q} + {1'b0, tinc_q};

  assign lreq.pos = pos_q;
  assign lreq.left_time = ltime_q;
  assign lreq.left_value = lval_q;
  assign lreq.height = height_q;
  assign lreq.width = width_q;

  always_comb begin
    if (state_q == S_RDR) raddr = AW'(li_next);
    else raddr = AW'(lidx_q);
  end

  bpe_store #(.MAX_POINTS(MAX_POINTS)) u_store (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (AW'(point_index_i)),
    .wtime_i  (point_time_i),
    .wvalue_i (point_value_i),
    .raddr_i  (raddr),
    .rtime_o  (rd_time),
    .rvalue_o (rd_value)
  );

  bpe_lerp u_lerp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (lerp_start),
    .req_i    (lreq),
    .done_o   (lerp_done),
    .result_o (lerp_res)
  );

  always_comb begin
    state_d = state_q; pos_d = pos_q; lidx_d = lidx_q;
    ltime_d = ltime_q; rtime_d = rtime_q; lval_d = lval_q; rval_d = rval_q;
    width_d = width_q; height_d = height_q; more_d = more_q;
    rs_val_d = rs_val_q; rs_end_d = rs_end_q; rs_smp_d = rs_smp_q; rs_err_d = rs_err_q;
    ov_d = ov_q; o_val_d = o_val_q; o_end_d = o_end_q; o_smp_d = o_smp_q; o_err_d = o_err_q;
    lerp_start = 1'b0;
    if (out_ready_i) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rs_val_d = '0; rs_end_d = 1'b0; rs_smp_d = 1'b0; rs_err_d = 1'b0;
          state_d = S_DONE;
          case (req_type_i)
            REQ_LOAD: rs_err_d = load_err;
            REQ_RESTART: begin
              pos_d = '0;
              lidx_d = '0;
              more_d = 1'b1;
              state_d = S_RDL;
            end
            REQ_TICK: begin
              rs_smp_d = 1'b1;
              if (!more_q) begin
                rs_val_d = rval_q;
                rs_end_d = 1'b1;
              end else if (width_q == '0) begin
                rs_val_d = rval_q;
                state_d = S_ADV;
              end else begin
                lerp_start = 1'b1;
                state_d = S_MATH;
              end
            end
            default: ;
          endcase
        end
      end
      S_MATH: begin
        if (lerp_done) begin
          rs_val_d = lerp_res;
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        pos_d = next_pos[32] ? '1 : next_pos[31:0];
        state_d = S_DONE;
        if (next_pos > {1'b0, rtime_q}) begin
          lidx_d = li_next;
          if (li_next + CW'(1) < eff) state_d = S_RDL;
          else more_d = 1'b0;
        end
      end
      S_RDL: state_d = S_RDR;
      S_RDR: begin
        ltime_d = rd_time;
        lval_d = rd_value;
        state_d = S_RDC;
      end
      S_RDC: begin
        rtime_d = rd_time;
        rval_d = rd_value;
        width_d = rd_time - ltime_q;
        height_d = 33'($signed(rd_value)) - 33'(lval_q);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          o_val_d = rs_val_q; o_end_d = rs_end_q; o_smp_d = rs_smp_q; o_err_d = rs_err_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pcount_q <= POINT_COUNT_RESET;
      tinc_q <= TIME_INC_RESET;
      pos_q <= '0; lidx_q <= '0;
      ltime_q <= '0; rtime_q <= '0; lval_q <= '0; rval_q <= '0;
      width_q <= '0; height_q <= '0; more_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_index_i == CFG_POINT_COUNT) pcount_q <= cfg_wdata_i[6:0];
      if (cfg_we_i && cfg_index_i == CFG_TIME_INC) tinc_q <= cfg_wdata_i;
      pos_q <= pos_d; lidx_q <= lidx_d;
      ltime_q <= ltime_d; rtime_q <= rtime_d; lval_q <= lval_d; rval_q <= rval_d;
      width_q <= width_d; height_q <= height_d; more_q <= more_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rs_val_q <= rs_val_d; rs_end_q <= rs_end_d; rs_smp_q <= rs_smp_d; rs_err_q <= rs_err_d;
    o_val_q <= o_val_d; o_end_q <= o_end_d; o_smp_q <= o_smp_d; o_err_q <= o_err_d;
  end

  assign out_valid_o = ov_q;
  assign sample_value_o = o_val_q;
  assign stream_ended_o = o_end_q;
  assign is_sample_o = o_smp_q;
  assign load_error_o = o_err_q;

  a_math_needs_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MATH |-> more_q && width_q != '0)
    else $error("Interpolation running on an ended stream or zero-width span.");

  a_done_only_in_math: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lerp_done |-> state_q == S_MATH)
    else $error("Interpolation result arrived outside the wait state.");

  a_write_only_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> accept && CW'(point_index_i) < eff)
    else $error("Table written outside a valid load transaction.");

  a_restart_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == REQ_RESTART |=> state_q == S_RDL && lidx_q == '0)
    else $error("Restart did not start the span read.");

endmodule
`default_nettype wire

[rtl/bpe_store.sv]
// Breakpoint table: time and value memories, one write and one registered read port.
// Depends on nothing but its parameter.
`default_nettype none
module bpe_store #(
  parameter int unsigned MAX_POINTS = 64,
  localparam int unsigned AW = $clog2(MAX_POINTS)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [31:0]   wtime_i,
  input  wire logic [31:0]   wvalue_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [31:0]   rtime_o,
  output logic      [31:0]   rvalue_o
);

  logic [31:0] time_mem [MAX_POINTS];
  logic [31:0] value_mem [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_mem[waddr_i]  <= wtime_i;
      value_mem[waddr_i] <= wvalue_i;
    end
    rtime_o  <= time_mem[raddr_i];
    rvalue_o <= value_mem[raddr_i];
  end

endmodule
`default_nettype wire

[rtl/bpe_lerp.sv]
// Serial interpolation unit: shift-add multiply, restoring divide, then saturation.
// Depends on bpe_pkg.
`default_nettype none
module bpe_lerp import bpe_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire lerp_req_t req_i,
  output logic           done_o,
  output logic [31:0]    result_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [65:0] mcand_q, mcand_d;
  logic [32:0] mplier_q, mplier_d;
  logic [65:0] acc_q, acc_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] width_q, width_d;
  logic        neg_q, neg_d;
  logic signed [31:0] left_q, left_d;
  logic [31:0] res_q, res_d;
  logic        done_q, done_d;

  logic signed [32:0] diff;
  logic [32:0] ad, ah, rem_sh;
  logic signed [35:0] sum;

  always_comb begin
    diff = $signed({1'b0, req_i.pos}) - $signed({1'b0, req_i.left_time});
    ad = diff[32] ? 33'(-diff) : 33'(diff);
    ah = req_i.height[32] ? 33'(-req_i.height) : 33'(req_i.height);
    rem_sh = {rem_q[31:0], acc_q[65]};
    sum = neg_q ? 36'(left_q) - $signed({1'b0, acc_q[34:0]})
                : 36'(left_q) + $signed({1'b0, acc_q[34:0]});

    phase_d = phase_q; cnt_d = cnt_q; mcand_d = mcand_q; mplier_d = mplier_q;
    acc_d = acc_q; rem_d = rem_q; width_d = width_q; neg_d = neg_q;
    left_d = left_q; res_d = res_q; done_d = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          mcand_d = {33'd0, ad};
          mplier_d = ah;
          acc_d = '0;
          width_d = req_i.width;
          neg_d = diff[32] ^ req_i.height[32];
          left_d = req_i.left_value;
          cnt_d = 7'd33;
          phase_d = PH_MUL;
        end
      end
      PH_MUL: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d = {mcand_q[64:0], 1'b0};
        mplier_d = {1'b0, mplier_q[32:1]};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          rem_d = '0;
          cnt_d = 7'd66;
          phase_d = PH_DIV;
        end
      end
      PH_DIV: begin
        acc_d = {acc_q[64:0], 1'b0};
        if (rem_sh >= {1'b0, width_q}) begin
          rem_d = rem_sh - {1'b0, width_q};
          acc_d[0] = 1'b1;
        end else begin
          rem_d = rem_sh;
        end
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) phase_d = PH_FIN;
      end
      PH_FIN: begin
        if (acc_q > QUOT_LIMIT) begin
          res_d = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (sum > VAL_MAX) begin
          res_d = 32'h7FFF_FFFF;
        end else if (sum < VAL_MIN) begin
          res_d = 32'h8000_0000;
        end else begin
          res_d = sum[31:0];
        end
        done_d = 1'b1;
        phase_d = PH_IDLE;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    mplier_q <= mplier_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    width_q <= width_d;
    neg_q <= neg_d;
    left_q <= left_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign result_o = res_q;

endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking bench for breakpoint_envelope_generator: directed and random transactions.
// Depends on bpe_pkg and the block's RTL; holds its own scoreboard with a predictor.
`timescale 1ns / 100ps

import bpe_pkg::*;

typedef struct packed {
  logic [31:0] sample;
  logic        ended;
  logic        is_sample;
  logic        lerr;
} env_result_t;

class envelope_scoreboard;
  logic [31:0] pt_time [64];
  logic [31:0] pt_val [64];
  logic [31:0] pos, lt, rt, width;
  int unsigned lidx;
  longint lv, rv, height;
  bit more;
  logic [6:0] pcount;
  logic [31:0] incr;
  env_result_t pending [$];
  int errors;

  function new();
    pos = 0; lt = 0; rt = 0; width = 0; lidx = 0;
    lv = 0; rv = 0; height = 0; more = 0;
    pcount = POINT_COUNT_RESET;
    incr = TIME_INC_RESET;
    errors = 0;
  endfunction

  function void set_reg(logic idx, logic [31:0] data);
    if (idx == CFG_POINT_COUNT) pcount = data[6:0];
    else incr = data;
  endfunction

  function int unsigned active_points();
    if (pcount < 2) return 2;
    if (pcount > 64) return 64;
    return pcount;
  endfunction

  function void pick_span(int unsigned li);
    if (li + 1 >= 64) return;
    lidx = li;
    lt = pt_time[li];
    lv = longint'(signed'(pt_val[li]));
    rt = pt_time[li + 1];
    rv = longint'(signed'(pt_val[li + 1]));
    width = rt - lt;
    height = rv - lv;
  endfunction

  function longint lerp_value();
    longint diff, sum;
    logic [63:0] ad, ah, q;
    bit neg;
    diff = longint'({32'b0, pos}) - longint'({32'b0, lt});
    ad = diff < 0 ? -diff : diff;
    ah = height < 0 ? -height : height;
    neg = (diff < 0) != (height < 0);
    q = (ad * ah) / {32'b0, width};
    if (q > 64'h2_0000_0000) sum = neg ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
    else sum = lv + (neg ? -longint'(q) : longint'(q));
    if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
    if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
    return sum;
  endfunction

  function void note_input(req_e req, logic [5:0] idx, logic [31:0] t, logic [31:0] v);
    env_result_t r;
    longint val;
    logic [32:0] nxt;
    r = '0;
    case (req)
      REQ_LOAD: begin
        if (idx >= active_points()) r.lerr = 1;
        else begin
          pt_time[idx] = t;
          pt_val[idx] = v;
        end
      end
      REQ_RESTART: begin
        pos = 0;
        pick_span(0);
        more = 1;
      end
      REQ_TICK: begin
        r.is_sample = 1;
        if (!more) begin
          val = rv;
          r.ended = 1;
        end else begin
          val = (width == 0) ? rv : lerp_value();
          nxt = {1'b0, pos} + {1'b0, incr};
          pos = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
          if (nxt > {1'b0, rt}) begin
            if (lidx + 2 < active_points()) pick_span(lidx + 1);
            else begin
              lidx = (lidx + 1) & 7'h7F;
              more = 0;
            end
          end
        end
        r.sample = val[31:0];
      end
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(env_result_t got);
    env_result_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("Unexpected result: %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("Mismatch: sample %h/%h ended %b/%b is_sample %b/%b load_error %b/%b (exp/act)",
                 want.sample, got.sample, want.ended, got.ended,
                 want.is_sample, got.is_sample, want.lerr, got.lerr);
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int ITEM_TARGET = 1250;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [1:0] req_type_i = '0;
  logic [5:0] point_index_i = '0;
  logic [31:0] point_time_i = '0;
  logic [31:0] point_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [31:0] sample_value_o;
  logic stream_ended_o, is_sample_o, load_error_o;
  logic cfg_we_i = 0;
  logic cfg_index_i = 0;
  logic [31:0] cfg_wdata_i = '0;

  envelope_scoreboard sb = new();
  bit no_gaps = 0;
  int sent = 0;
  int cycles = 0;

  breakpoint_envelope_generator dut (.*);

  initial begin
    forever begin
      #4 clk_i = ~clk_i;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** breakpoint_envelope_generator: FAILED **");
      $finish;
    end
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send(req_e req, int unsigned idx, logic [31:0] t, logic [31:0] v);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    req_type_i <= req;
    point_index_i <= 6'(idx);
    point_time_i <= t;
    point_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(req, 6'(idx), t, v);
    if (req != REQ_NONE) sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  task automatic noise(int unsigned n);
    case ($urandom_range(0, 3))
      0: send(REQ_NONE, $urandom(), $urandom(), $urandom());
      1: send(REQ_LOAD, (n < 64) ? $urandom_range(n, 63) : $urandom_range(0, 63),
              $urandom(), $urandom());
      2: send(REQ_TICK, $urandom(), $urandom(), $urandom());
      default: send(REQ_LOAD, $urandom_range(0, n - 1), $urandom(), pick_value());
    endcase
  endtask

  task automatic run_phase();
    logic [31:0] pc, inc, t;
    int unsigned n, ticks;
    bit ordered;
    case ($urandom_range(0, 9))
      0: pc = 2;
      1: pc = 64;
      2: pc = $urandom_range(0, 1);
      3: pc = $urandom_range(65, 127);
      default: pc = $urandom_range(2, 12);
    endcase
    case ($urandom_range(0, 5))
      0: inc = 1;
      1: inc = 32'hFFFF_FFFF;
      2: inc = $urandom();
      default: inc = $urandom_range(1, 1 << 20);
    endcase
    wait_idle();
    write_reg(CFG_POINT_COUNT, pc);
    write_reg(CFG_TIME_INC, inc);
    no_gaps = ($urandom_range(0, 3) == 0);
    n = sb.active_points();
    ordered = ($urandom_range(0, 4) != 0);
    t = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3 * inc);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) noise(n);
      send(REQ_LOAD, i, t, pick_value());
      t = ordered ? t + inc * $urandom_range(0, 3) + $urandom_range(0, inc) : $urandom();
    end
    send(REQ_RESTART, $urandom(), $urandom(), $urandom());
    ticks = n * 4 + $urandom_range(1, 6);
    if (ticks > 150) ticks = 150;
    for (int unsigned i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 14) == 0) noise(n);
      if ($urandom_range(0, 60) == 0) send(REQ_RESTART, $urandom(), $urandom(), $urandom());
      send(REQ_TICK, $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    int gap;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result({sample_value_o, stream_ended_o, is_sample_o, load_error_o});
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send(REQ_TICK, 0, 0, 0);
    send(REQ_NONE, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(REQ_LOAD, 2, 32'h1, 32'h1);
    send(REQ_LOAD, 63, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send(REQ_LOAD, 0, 32'h0, 32'h8000_0000);
    send(REQ_LOAD, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send(REQ_RESTART, 0, 0, 0);
    repeat (3) send(REQ_TICK, 0, 0, 0);
    send(REQ_LOAD, 1, 32'h0, 32'h0001_2345);
    send(REQ_RESTART, 0, 0, 0);
    repeat (3) send(REQ_TICK, 0, 0, 0);
    send(REQ_LOAD, 0, 32'h1000_0000, 32'h7FFF_FFFF);
    send(REQ_LOAD, 1, 32'h0000_0010, 32'h8000_0000);
    send(REQ_RESTART, 0, 0, 0);
    repeat (2) send(REQ_TICK, 0, 0, 0);
    wait_idle();
    write_reg(CFG_TIME_INC, 32'hFFFF_FFFF);
    send(REQ_RESTART, 0, 0, 0);
    repeat (3) send(REQ_TICK, 0, 0, 0);

    wait_idle();
    write_reg(CFG_POINT_COUNT, 64);
    for (int i = 0; i < 64; i++) send(REQ_LOAD, i, $urandom(), $urandom());

    while (sent < ITEM_TARGET) run_phase();

    wait_idle();
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** breakpoint_envelope_generator: PASSED **");
    end else begin
      $display("** breakpoint_envelope_generator: FAILED **");
    end
    $finish;
  end
endmodule

[files.f]
rtl/bpe_pkg.sv
rtl/bpe_store.sv
rtl/bpe_lerp.sv
rtl/breakpoint_envelope_generator.sv
bench/tb.sv
